// ===== sv/ebp_pkg.sv =====
// Shared constants, codes and types for the EDID base block parser.
package ebp_pkg;

  localparam int BlockBytes = 128;
  localparam int TextChars  = 12;
  localparam int SumQDepth  = 2;

  localparam logic [7:0] DescFirst   = 8'd54;
  localparam logic [7:0] DescEnd     = 8'd126;
  localparam logic [4:0] DescLastOfs = 5'd17;
  localparam logic [4:0] OfsFlag0    = 5'd0;
  localparam logic [4:0] OfsFlag1    = 5'd2;
  localparam logic [4:0] OfsTag      = 5'd3;
  localparam logic [4:0] OfsStrFirst = 5'd5;
  localparam logic [4:0] OfsStrLast  = 5'd16;

  localparam logic [7:0] TagName   = 8'hFC;
  localparam logic [7:0] TagSerial = 8'hFF;
  localparam logic [7:0] TagText   = 8'hFE;

  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [3:0] MaxReplace = 4'd4;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatShort  = 2'd1;
  localparam logic [1:0] StatHeader = 2'd2;

  localparam logic [1:0] KindIds    = 2'd0;
  localparam logic [1:0] KindName   = 2'd1;
  localparam logic [1:0] KindSerial = 2'd2;
  localparam logic [1:0] KindText   = 2'd3;

  typedef logic [TextChars-1:0][7:0] text_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [23:0]      maker_code;
    logic [31:0]      serial_value;
    text_t [2:0]      text;
    logic [2:0][3:0]  text_length;
  } sum_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [1:0]  status;
    logic [23:0] maker_code;
    logic [31:0] serial_value;
    logic [63:0] text_head;
    logic [31:0] text_tail;
    logic [3:0]  text_length;
    logic        last;
  } res_t;

endpackage

// ===== sv/ebp_front.sv =====
// Byte parser that builds one block summary per end-of-block transfer.
module ebp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_block_i,
  output logic          sum_push_o,
  output ebp_pkg::sum_t sum_o
);
  import ebp_pkg::*;

  logic [7:0]       pos_q, pos_d;
  logic             hdr_q, hdr_d;
  logic [15:0]      maker_q, maker_d;
  logic [31:0]      serial_q, serial_d;
  logic [4:0]       off_q, off_d;
  logic             skip_q, skip_d;
  logic [7:0]       tag_q, tag_d;
  text_t            work_q, work_d;
  logic             stop_q, stop_d;
  logic [3:0]       wlen_q, wlen_d;
  logic [3:0]       wrep_q, wrep_d;
  text_t [2:0]      kept_q, kept_d;
  logic [2:0][3:0]  klen_q, klen_d;
  logic             commit;
  logic             has_slot;
  logic [1:0]       slot;
  logic [3:0]       clen;
  text_t            cchars;
  logic [7:0]       b;
  logic [7:0]       c1, c2, c3;

  assign b = data_byte_i;

  always_comb begin
    pos_d    = pos_q;
    hdr_d    = hdr_q;
    maker_d  = maker_q;
    serial_d = serial_q;
    off_d    = off_q;
    skip_d   = skip_q;
    tag_d    = tag_q;
    work_d   = work_q;
    stop_d   = stop_q;
    wlen_d   = wlen_q;
    wrep_d   = wrep_q;
    commit   = 1'b0;
    if (accept_i && !pos_q[7]) begin
      pos_d = pos_q + 8'd1;
      if (pos_q == 8'd0 && b != 8'h00) hdr_d = 1'b1;
      if (pos_q == 8'd1 && b != 8'hFF) hdr_d = 1'b1;
      if (pos_q == 8'd8) maker_d[15:8] = b;
      if (pos_q == 8'd9) maker_d[7:0] = b;
      if (pos_q >= 8'd12 && pos_q <= 8'd15) serial_d[{pos_q[1:0], 3'b000} +: 8] = b;
      if (pos_q >= DescFirst && pos_q < DescEnd) begin
        off_d = (off_q == DescLastOfs) ? 5'd0 : off_q + 5'd1;
        if (off_q == OfsFlag0) begin
          skip_d = (b != 8'h00);
          tag_d  = 8'h00;
          work_d = '0;
          stop_d = 1'b0;
          wlen_d = 4'd0;
          wrep_d = 4'd0;
        end else if (off_q == OfsFlag1) begin
          if (b != 8'h00) skip_d = 1'b1;
        end else if (off_q == OfsTag) begin
          tag_d = b;
        end else if (off_q >= OfsStrFirst && off_q <= OfsStrLast) begin
          if (!stop_q) begin
            if (b == 8'h00 || b == 8'h0A || b == 8'h0D) begin
              stop_d = 1'b1;
            end else if (wlen_q < 4'(TextChars)) begin
              if (b >= 8'h20 && b <= 8'h7E) begin
                work_d[wlen_q] = b;
              end else begin
                work_d[wlen_q] = CharDash;
                wrep_d = wrep_q + 4'd1;
              end
              wlen_d = wlen_q + 4'd1;
            end
          end
          if (off_q == OfsStrLast) commit = 1'b1;
        end
      end
    end
  end

  always_comb begin
    has_slot = 1'b1;
    slot     = 2'd0;
    case (tag_d)
      TagName:   slot = 2'd0;
      TagSerial: slot = 2'd1;
      TagText:   slot = 2'd2;
      default:   has_slot = 1'b0;
    endcase
    clen = (wrep_d > MaxReplace) ? 4'd0 : wlen_d;
    for (int i = 0; i < TextChars; i++) begin
      cchars[i] = (4'(i) < clen) ? work_d[i] : 8'h00;
    end
    kept_d = kept_q;
    klen_d = klen_q;
    if (commit && !skip_d && has_slot) begin
      kept_d[slot] = cchars;
      klen_d[slot] = clen;
    end
  end

  assign c1 = 8'h40 + {3'b000, maker_d[14:10]};
  assign c2 = 8'h40 + {3'b000, maker_d[9:8], maker_d[7:5]};
  assign c3 = 8'h40 + {3'b000, maker_d[4:0]};

  always_comb begin
    sum_o.status       = pos_d[7] ? (hdr_d ? StatHeader : StatOk) : StatShort;
    sum_o.maker_code   = {c1, c2, c3};
    sum_o.serial_value = serial_d;
    sum_o.text         = kept_d;
    sum_o.text_length  = klen_d;
  end

  assign sum_push_o = accept_i && end_of_block_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      hdr_q    <= 1'b0;
      maker_q  <= '0;
      serial_q <= '0;
      off_q    <= '0;
      skip_q   <= 1'b0;
      tag_q    <= '0;
      work_q   <= '0;
      stop_q   <= 1'b0;
      wlen_q   <= '0;
      wrep_q   <= '0;
      kept_q   <= '0;
      klen_q   <= '0;
    end else if (accept_i && end_of_block_i) begin
      pos_q    <= '0;
      hdr_q    <= 1'b0;
      maker_q  <= '0;
      serial_q <= '0;
      off_q    <= '0;
      skip_q   <= 1'b0;
      tag_q    <= '0;
      work_q   <= '0;
      stop_q   <= 1'b0;
      wlen_q   <= '0;
      wrep_q   <= '0;
      kept_q   <= '0;
      klen_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      hdr_q    <= hdr_d;
      maker_q  <= maker_d;
      serial_q <= serial_d;
      off_q    <= off_d;
      skip_q   <= skip_d;
      tag_q    <= tag_d;
      work_q   <= work_d;
      stop_q   <= stop_d;
      wlen_q   <= wlen_d;
      wrep_q   <= wrep_d;
      kept_q   <= kept_d;
      klen_q   <= klen_d;
    end
  end

endmodule

// ===== sv/ebp_sumq.sv =====
// Short queue of block summaries between the parser and the result emitter.
module ebp_sumq #(
  parameter int Depth = ebp_pkg::SumQDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  ebp_pkg::sum_t wr_data_i,
  output logic          full_o,
  input  logic          rd_i,
  output ebp_pkg::sum_t rd_data_o,
  output logic          valid_o
);
  import ebp_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sum_t              mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, wptr_d;
  logic [PtrW-1:0]   rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    if (do_rd) rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    if (do_wr && !do_rd) cnt_d = cnt_q + CntW'(1);
    if (do_rd && !do_wr) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== sv/ebp_back.sv =====
// Result emitter that turns each block summary into one or four results.
module ebp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ebp_pkg::sum_t sum_i,
  input  logic          sum_valid_i,
  output logic          sum_pop_o,
  input  logic          pop,
  output logic          empty,
  output ebp_pkg::res_t res_o
);
  import ebp_pkg::*;

  logic [1:0]  idx_q, idx_d;
  logic        ov_q, ov_d;
  res_t        res_q, res_d;
  logic        load;
  logic [1:0]  slot;
  logic        is_last;

  assign empty = !ov_q;
  assign res_o = res_q;
  assign load  = sum_valid_i && (!ov_q || pop);
  assign slot  = idx_q - 2'd1;

  always_comb begin
    is_last = (sum_i.status != StatOk) || (idx_q == KindText);
    res_d   = '0;
    if (idx_q == KindIds) begin
      res_d.item_kind = KindIds;
      res_d.status    = sum_i.status;
      if (sum_i.status == StatOk) begin
        res_d.maker_code   = sum_i.maker_code;
        res_d.serial_value = sum_i.serial_value;
      end
    end else begin
      res_d.item_kind   = idx_q;
      res_d.text_head   = sum_i.text[slot][7:0];
      res_d.text_tail   = sum_i.text[slot][11:8];
      res_d.text_length = sum_i.text_length[slot];
    end
    res_d.last = is_last;
    sum_pop_o  = load && is_last;
    idx_d      = idx_q;
    if (load) idx_d = is_last ? KindIds : idx_q + 2'd1;
    ov_d = ov_q;
    if (load) ov_d = 1'b1;
    else if (pop) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= KindIds;
      ov_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

endmodule

// ===== sv/edid_base_block_parser_core.sv =====
// Top level of the EDID base block parser: parser, summary queue, emitter.
//
// Input channel: drive data_byte_i and end_of_block_i with push; a transfer
// happens on a clock edge where push is high and full is low. Bytes arrive in
// block order from offset 0, and end_of_block_i marks the last byte supplied.
// One byte is taken every cycle while full is low; full rises only while the
// summary queue holds as many finished blocks as it has entries.
// Result channel: while empty is low the oldest result is on the result
// ports; it transfers on an edge where pop is high. A block gives one result
// when its status is bad and four results otherwise, the final one with
// last_o set. After the end-of-block transfer the first result passes
// through the queue and the output register, then one result per cycle
// follows while pop is high. On a receiver stall results wait in the output
// register, summaries wait in the queue and the parser takes bytes until full
// rises. Reset clears the parser, queue and emitter state, not the result data.
module edid_base_block_parser_core #(
  parameter int SumQDepth = ebp_pkg::SumQDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_block_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  item_kind_o,
  output logic [1:0]  status_o,
  output logic [23:0] maker_code_o,
  output logic [31:0] serial_value_o,
  output logic [63:0] text_head_o,
  output logic [31:0] text_tail_o,
  output logic [3:0]  text_length_o,
  output logic        last_o
);
  import ebp_pkg::*;

  logic  accept;
  logic  sum_push;
  sum_t  sum_in;
  sum_t  sum_head;
  logic  sum_valid;
  logic  sum_pop;
  res_t  res;

  assign accept = push && !full;

  ebp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .end_of_block_i (end_of_block_i),
    .sum_push_o     (sum_push),
    .sum_o          (sum_in)
  );

  ebp_sumq #(
    .Depth (SumQDepth)
  ) u_sumq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (sum_push),
    .wr_data_i (sum_in),
    .full_o    (full),
    .rd_i      (sum_pop),
    .rd_data_o (sum_head),
    .valid_o   (sum_valid)
  );

  ebp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_i       (sum_head),
    .sum_valid_i (sum_valid),
    .sum_pop_o   (sum_pop),
    .pop         (pop),
    .empty       (empty),
    .res_o       (res)
  );

  assign item_kind_o    = res.item_kind;
  assign status_o       = res.status;
  assign maker_code_o   = res.maker_code;
  assign serial_value_o = res.serial_value;
  assign text_head_o    = res.text_head;
  assign text_tail_o    = res.text_tail;
  assign text_length_o  = res.text_length;
  assign last_o         = res.last;

endmodule
